// ===== hdl/rational_fraction_alu_assert.svh =====
// ----------------------------------------------------------------------------
// rational_fraction_alu assertion macros
// Concurrent assertion shorthands for the rational fraction unit. They
// expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_FRACTION_ALU_ASSERT_SVH
`define RATIONAL_FRACTION_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg
// Widths, request codes and sequencer states of the rational fraction unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfa_pkg;

  // Width of one fraction part.
  localparam int VALUE_BITS = 16;
  // A cross product and the sum of two of them.
  localparam int PROD_W     = 2 * VALUE_BITS;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = PROD_W;
  // Remainder of the restoring divider, one bit above the divisor.
  localparam int REM_W      = NUM_W + 1;
  // Wide enough to count the NUM_W divider steps and the gcd shift.
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam int REQ_W      = 3;
  localparam int IN_DATA_W  = 4 * VALUE_BITS;
  localparam int OUT_USED_W = NUM_W + DEN_W + 3;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_MAKE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MUL     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CMP     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ADD_RED = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_FORM = 6'b000100,
    S_GCD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

// ===== hdl/rational_fraction_alu.sv =====
// ----------------------------------------------------------------------------
// rational_fraction_alu: make, add, multiply, compare and add-then-reduce on two fractions.
// Flow: an accepted add, multiply, compare or unknown code passes through S_MUL, S_FORM and
// S_DONE; make and add_reduce add the binary gcd and, unless the gcd is 1, 33 divider steps.
// One item at a time: a new item is accepted only in S_IDLE, after the previous result has
// moved into the output register, which happens only once that register is free.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rational_fraction_alu_assert.svh"

// The block works on one item at a time under a small one-hot sequencer.
//
// S_MUL runs one VALUE_BITS x VALUE_BITS multiplier, one step per product, and
// registers the four cross products ad*bd, ad*bn, an*bd and an*bn. S_FORM
// picks the result for the request type with one wide adder and one compare.
// When the result must be reduced, S_GCD runs a binary gcd (one compare,
// one subtract and shifts per cycle), and S_DIV divides numerator and
// denominator by the gcd with a restoring divider, one quotient bit a cycle.
// S_DONE moves the result into the output register once that register is
// free, so the next item can be accepted while the previous result waits.
module rational_fraction_alu
  import rfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // a_num [15:0], a_den [31:16], b_num [47:32], b_den [63:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type [2:0]
  input  logic [REQ_W-1:0]      in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // res_num [32:0], res_den [64:33], res_empty [65], is_equal [66],
  // is_not_equal [67], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Sequencer and captured request.
  state_t                  state_r, state_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [VALUE_BITS-1:0]   an_r, ad_r, bn_r, bd_r;
  logic [VALUE_BITS-1:0]   an_nxt, ad_nxt, bn_nxt, bd_nxt;

  // Cross products, indexed by the multiplier step that wrote them:
  // 0 ad*bd, 1 ad*bn, 2 an*bd, 3 an*bn.
  logic [PROD_W-1:0]       prod_r [4];
  logic [PROD_W-1:0]       mul_res;
  logic [VALUE_BITS-1:0]   mul_a, mul_b;

  // Working result; the denominator carries one spare top bit so the
  // divider handles both parts the same way.
  logic [NUM_W-1:0]        rn_r, rn_nxt;
  logic [NUM_W-1:0]        rd_r, rd_nxt;
  logic                    eq_r, eq_nxt, ne_r, ne_nxt;

  // Binary gcd and divider state.
  logic [NUM_W-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [NUM_W-1:0]        g_r, g_nxt;
  logic [REM_W-1:0]        remn_r, remn_nxt, remd_r, remd_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // Shared arithmetic.
  logic [NUM_W-1:0]        sum;
  logic                    x_ge;
  logic [NUM_W-1:0]        big, little, diff, gcd_or;
  logic [REM_W-1:0]        tn, td, g_ext;
  logic                    out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // One multiplier, operands chosen by the step: step bit 1 picks the
  // a part (den/num), step bit 0 picks the b part (den/num).
  assign mul_a   = step_r[1] ? an_r : ad_r;
  assign mul_b   = step_r[0] ? bn_r : bd_r;
  assign mul_res = mul_a * mul_b;

  assign sum = {1'b0, prod_r[1]} + {1'b0, prod_r[2]};

  // Binary gcd step operands.
  assign x_ge   = (x_r >= y_r);
  assign big    = x_ge ? x_r : y_r;
  assign little = x_ge ? y_r : x_r;
  assign diff   = big - little;
  assign gcd_or = x_r | y_r;

  // Restoring divider step for numerator and denominator.
  assign g_ext = {1'b0, g_r};
  assign tn    = {remn_r[REM_W-2:0], rn_r[NUM_W-1]};
  assign td    = {remd_r[REM_W-2:0], rd_r[NUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    req_nxt       = req_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    eq_nxt        = eq_r;
    ne_nxt        = ne_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    remn_nxt      = remn_r;
    remd_nxt      = remd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser;
          an_nxt    = in_tdata[VALUE_BITS-1:0];
          ad_nxt    = in_tdata[2*VALUE_BITS-1:VALUE_BITS];
          bn_nxt    = in_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
          bd_nxt    = in_tdata[4*VALUE_BITS-1:3*VALUE_BITS];
          step_nxt  = 2'd0;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = S_FORM;
        end
      end

      S_FORM: begin
        rn_nxt    = '0;
        rd_nxt    = '0;
        eq_nxt    = 1'b0;
        ne_nxt    = 1'b0;
        state_nxt = S_DONE;
        case (req_r)
          REQ_MAKE: begin
            // A fraction with a zero part stays empty; otherwise reduce.
            if (an_r != '0 && ad_r != '0) begin
              rn_nxt    = NUM_W'(an_r);
              rd_nxt    = NUM_W'(ad_r);
              state_nxt = S_GCD;
            end
          end
          REQ_ADD, REQ_ADD_RED: begin
            if (bd_r != '0) begin
              rn_nxt = sum;
              rd_nxt = {1'b0, prod_r[0]};
              // A zero part (empty a, or a zero sum) is left unreduced.
              if (req_r == REQ_ADD_RED && sum != '0 && prod_r[0] != '0) begin
                state_nxt = S_GCD;
              end
            end
          end
          REQ_MUL: begin
            if (ad_r != '0 && bd_r != '0) begin
              rn_nxt = {1'b0, prod_r[3]};
              rd_nxt = {1'b0, prod_r[0]};
            end
          end
          REQ_CMP: begin
            if (ad_r != '0) begin
              eq_nxt = (prod_r[2] == prod_r[1]);
              ne_nxt = (prod_r[2] != prod_r[1]);
            end
          end
          default: begin
          end
        endcase
        x_nxt = rn_nxt;
        y_nxt = rd_nxt;
        k_nxt = '0;
      end

      S_GCD: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt    = NUM_W'(gcd_or << k_r);
          remn_nxt = '0;
          remd_nxt = '0;
          cnt_nxt  = '0;
          // A gcd of one leaves the fraction as it is.
          if (k_r == '0 && gcd_or == NUM_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_ge) begin
          // Both odd: the difference is even, so halve it at once.
          x_nxt = diff >> 1;
        end else begin
          y_nxt = diff >> 1;
        end
      end

      S_DIV: begin
        // Dividends shift out at the top while quotient bits enter below.
        if (tn >= g_ext) begin
          remn_nxt = tn - g_ext;
          rn_nxt   = {rn_r[NUM_W-2:0], 1'b1};
        end else begin
          remn_nxt = tn;
          rn_nxt   = {rn_r[NUM_W-2:0], 1'b0};
        end
        if (td >= g_ext) begin
          remd_nxt = td - g_ext;
          rd_nxt   = {rd_r[NUM_W-2:0], 1'b1};
        end else begin
          remd_nxt = td;
          rd_nxt   = {rd_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({ne_r, eq_r, (rd_r[DEN_W-1:0] == '0),
                                       rd_r[DEN_W-1:0], rn_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    req_r      <= req_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    rn_r       <= rn_nxt;
    rd_r       <= rd_nxt;
    eq_r       <= eq_nxt;
    ne_r       <= ne_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    k_r        <= k_nxt;
    g_r        <= g_nxt;
    remn_r     <= remn_nxt;
    remd_r     <= remd_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == S_MUL) begin
      prod_r[step_r] <= mul_res;
    end
  end

  // An accepted item always starts the multiplier sequence.
  `RFA_ASSERT_NEXT(a_accept_starts_mul, in_tvalid && in_tready, state_r == S_MUL, "accepted item did not start the multiplier")
  // The divider never runs with a zero divisor.
  `RFA_ASSERT_SAME(a_div_nonzero, state_r == S_DIV, g_r != '0, "divider running with zero gcd")
  // The compare flags are never both set.
  `RFA_ASSERT_SAME(a_flags_exclusive, out_valid_r, !(out_data_r[NUM_W+DEN_W+1] && out_data_r[NUM_W+DEN_W+2]), "equal and not_equal both set")
  // The empty flag follows the result denominator.
  `RFA_ASSERT_SAME(a_empty_matches, out_valid_r, out_data_r[NUM_W+DEN_W] == (out_data_r[NUM_W+DEN_W-1:NUM_W] == '0), "empty flag disagrees with denominator")

endmodule
